// ----- hw/rtl/pppoa_encap_detect_strip_top_assert.svh -----
// Assertion helpers for the RTL files; ped_burst.sv includes them.
`ifndef PPPOA_ENCAP_DETECT_STRIP_TOP_ASSERT_SVH
`define PPPOA_ENCAP_DETECT_STRIP_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define PED_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define PED_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/ped_pkg.sv -----
`default_nettype none

package ped_pkg;

   localparam int MaxRes = 5;
   localparam int CntW   = $clog2(MaxRes + 1);

   localparam logic [1:0] MODE_AUTO  = 2'd0;
   localparam logic [1:0] MODE_VCMUX = 2'd1;
   localparam logic [1:0] MODE_LLC   = 2'd2;

   localparam logic [1:0] KIND_RX    = 2'd0;
   localparam logic [1:0] KIND_TX    = 2'd1;
   localparam logic [1:0] KIND_ERR   = 2'd2;
   localparam logic [1:0] KIND_EMPTY = 2'd3;

   localparam logic FUNC_RX = 1'b0;

   localparam logic CSR_ENCAP_MODE = 1'b0;
   localparam logic CSR_CHANNEL_UP = 1'b1;

   localparam logic [7:0] LCP_HI = 8'hc0;
   localparam logic [7:0] LCP_LO = 8'h21;
   localparam logic [7:0] LLC_B0 = 8'hfe;

   // Header positions past the LLC prefix: LCP bytes, then the vc-mux LCP wait
   localparam logic [2:0] POS_LLC_END = 3'd4;
   localparam logic [2:0] POS_LCP_LO  = 3'd5;
   localparam logic [2:0] POS_VC_LO   = 3'd6;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic       pkt_last;
   } req_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_word_type;

   typedef struct packed {
      logic [CntW-1:0]                cnt;
      rsp_word_type [MaxRes-1:0]      res;
   } burst_type;

   // LLC header followed by the LCP protocol id
   function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
      logic [7:0] b;
      unique case (pos)
         3'd0:    b = 8'hfe;
         3'd1:    b = 8'hfe;
         3'd2:    b = 8'h03;
         3'd3:    b = 8'hcf;
         3'd4:    b = 8'hc0;
         3'd5:    b = 8'h21;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ped_stream_if.sv -----
`default_nettype none

interface ped_stream_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   logic       pkt_last;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (
      output valid, func, data_byte, pkt_last, kind, out_byte, out_last,
      input  ready
   );
   modport sink (
      input  valid, func, data_byte, pkt_last, kind, out_byte, out_last,
      output ready
   );
endinterface

`default_nettype wire

// ----- hw/rtl/ped_core.sv -----
`default_nettype none

module ped_core
   import ped_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [1:0]   csr_wdata,
   input  wire logic         fire,
   input  wire req_word_type word,
   output burst_type         burst
);

   logic [1:0] cur_mode_ff, cur_mode_in;
   logic       chan_up_ff;
   logic [2:0] hpos_ff, hpos_in;
   logic       drop_ff, drop_in;
   logic       hdone_ff, hdone_in;
   logic       silent_ff, silent_in;
   logic       tx_start_ff, tx_start_in;

   logic       matched;
   logic       lock;
   logic [1:0] lock_mode;
   logic [7:0] b;
   logic       last;

   assign b    = word.data_byte;
   assign last = word.pkt_last;

   always_comb begin
      cur_mode_in = cur_mode_ff;
      hpos_in     = hpos_ff;
      drop_in     = drop_ff;
      hdone_in    = hdone_ff;
      silent_in   = silent_ff;
      tx_start_in = tx_start_ff;
      matched     = 1'b0;
      lock        = 1'b0;
      lock_mode   = MODE_VCMUX;
      burst       = '0;

      if (fire) begin
         if (word.func != FUNC_RX) begin
            if (tx_start_ff && cur_mode_ff == MODE_LLC) begin
               burst.cnt    = CntW'(5);
               burst.res[0] = '{KIND_TX, hdr_byte(3'd0), 1'b0};
               burst.res[1] = '{KIND_TX, hdr_byte(3'd1), 1'b0};
               burst.res[2] = '{KIND_TX, hdr_byte(3'd2), 1'b0};
               burst.res[3] = '{KIND_TX, hdr_byte(3'd3), 1'b0};
               burst.res[4] = '{KIND_TX, b, last};
            end else begin
               burst.cnt    = CntW'(1);
               burst.res[0] = '{KIND_TX, b, last};
            end
            tx_start_in = last;
         end else if (drop_ff) begin
            if (last) begin
               if (!silent_ff) begin
                  burst.cnt    = CntW'(1);
                  burst.res[0] = '{KIND_ERR, 8'h00, 1'b1};
               end
               hpos_in   = '0;
               drop_in   = 1'b0;
               hdone_in  = 1'b0;
               silent_in = 1'b0;
            end
         end else if (!hdone_ff && hpos_ff == '0 && !chan_up_ff) begin
            // channel down at packet start: swallow the whole packet
            if (last) begin
               hpos_in   = '0;
               drop_in   = 1'b0;
               hdone_in  = 1'b0;
               silent_in = 1'b0;
            end else begin
               drop_in   = 1'b1;
               silent_in = 1'b1;
            end
         end else if (hdone_ff || cur_mode_ff == MODE_VCMUX) begin
            hdone_in     = 1'b1;
            burst.cnt    = CntW'(1);
            burst.res[0] = '{KIND_RX, b, last};
            if (last) begin
               hpos_in   = '0;
               drop_in   = 1'b0;
               hdone_in  = 1'b0;
               silent_in = 1'b0;
            end
         end else begin
            if (cur_mode_ff == MODE_LLC) begin
               if (hpos_ff < POS_LLC_END && b == hdr_byte(hpos_ff)) begin
                  matched = 1'b1;
                  hpos_in = hpos_ff + 3'd1;
                  if (hpos_ff == POS_LLC_END - 3'd1) begin
                     hdone_in = 1'b1;
                  end
               end
            end else begin
               // autodetect (and the unused mode code)
               if (hpos_ff == '0) begin
                  if (b == LLC_B0) begin
                     hpos_in = 3'd1;
                     matched = 1'b1;
                  end else if (b == LCP_HI) begin
                     hpos_in = POS_VC_LO;
                     matched = 1'b1;
                  end
               end else if (hpos_ff <= POS_LCP_LO) begin
                  if (b == hdr_byte(hpos_ff)) begin
                     matched = 1'b1;
                     if (hpos_ff == POS_LCP_LO) begin
                        lock      = 1'b1;
                        lock_mode = MODE_LLC;
                     end else begin
                        hpos_in = hpos_ff + 3'd1;
                     end
                  end
               end else if (hpos_ff == POS_VC_LO) begin
                  if (b == LCP_LO) begin
                     matched   = 1'b1;
                     lock      = 1'b1;
                     lock_mode = MODE_VCMUX;
                  end
               end
            end

            if (lock) begin
               // LCP id was consumed while matching; regenerate it
               cur_mode_in  = lock_mode;
               hdone_in     = 1'b1;
               burst.cnt    = CntW'(2);
               burst.res[0] = '{KIND_RX, LCP_HI, 1'b0};
               burst.res[1] = '{KIND_RX, LCP_LO, last};
            end

            if (!matched) begin
               if (last) begin
                  burst.cnt    = CntW'(1);
                  burst.res[0] = '{KIND_ERR, 8'h00, 1'b1};
                  hpos_in      = '0;
                  drop_in      = 1'b0;
                  hdone_in     = 1'b0;
                  silent_in    = 1'b0;
               end else begin
                  drop_in   = 1'b1;
                  silent_in = 1'b0;
               end
            end else if (last) begin
               if (!hdone_in) begin
                  burst.cnt    = CntW'(1);
                  burst.res[0] = '{KIND_ERR, 8'h00, 1'b1};
               end else if (!lock) begin
                  burst.cnt    = CntW'(1);
                  burst.res[0] = '{KIND_EMPTY, 8'h00, 1'b1};
               end
               hpos_in   = '0;
               drop_in   = 1'b0;
               hdone_in  = 1'b0;
               silent_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mode_ff <= MODE_AUTO;
         chan_up_ff  <= 1'b0;
         hpos_ff     <= '0;
         drop_ff     <= 1'b0;
         hdone_ff    <= 1'b0;
         silent_ff   <= 1'b0;
         tx_start_ff <= 1'b1;
      end else begin
         hpos_ff     <= hpos_in;
         drop_ff     <= drop_in;
         hdone_ff    <= hdone_in;
         silent_ff   <= silent_in;
         tx_start_ff <= tx_start_in;
         if (csr_we && csr_index == CSR_ENCAP_MODE) begin
            cur_mode_ff <= csr_wdata;
         end else begin
            cur_mode_ff <= cur_mode_in;
         end
         if (csr_we && csr_index == CSR_CHANNEL_UP) begin
            chan_up_ff <= csr_wdata[0];
         end
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ped_burst.sv -----
`default_nettype none

`include "pppoa_encap_detect_strip_top_assert.svh"

module ped_burst
   import ped_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire burst_type burst,
   output logic           free,
   ped_stream_if.source   rsp_ch
);

   logic [CntW-1:0]    cnt_ff, cnt_in;
   rsp_word_type       res_ff [MaxRes];
   rsp_word_type       res_in [MaxRes];
   logic               take;

   assign take = rsp_ch.valid && rsp_ch.ready;
   assign free = (cnt_ff == '0) || (cnt_ff == CntW'(1) && take);

   assign rsp_ch.valid     = cnt_ff != '0;
   assign rsp_ch.kind      = res_ff[0].kind;
   assign rsp_ch.out_byte  = res_ff[0].out_byte;
   assign rsp_ch.out_last  = res_ff[0].out_last;
   assign rsp_ch.func      = 1'b0;
   assign rsp_ch.data_byte = 8'h00;
   assign rsp_ch.pkt_last  = 1'b0;

   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < MaxRes; i++) begin
         res_in[i] = res_ff[i];
      end
      if (load) begin
         cnt_in = burst.cnt;
         for (int i = 0; i < MaxRes; i++) begin
            res_in[i] = burst.res[i];
         end
      end else if (take) begin
         // pop the head word, shift the rest down
         cnt_in = cnt_ff - CntW'(1);
         for (int i = 0; i < MaxRes - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxRes; i++) begin
         res_ff[i] <= res_in[i];
      end
   end

   `PED_ASSERT_NEVER(a_load_busy, clock, reset, load && !free, "burst loaded while busy")
   `PED_ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > CntW'(MaxRes), "burst count overflow")
   `PED_ASSERT(a_shift, clock, reset, take && !load && cnt_ff > CntW'(1) |=> rsp_ch.valid && rsp_ch.kind == $past(res_ff[1].kind) && rsp_ch.out_byte == $past(res_ff[1].out_byte), "burst shift lost a word")

endmodule

`default_nettype wire

// ----- hw/rtl/pppoa_encap_detect_strip_top.sv -----
// Channel  Dir  Handshake      Payload
// req_ch   in   valid/ready    func, data_byte, pkt_last
// rsp_ch   out  valid/ready    kind, out_byte, out_last
// csr      in   csr_we         csr_index, csr_wdata (no read-back)
//
// One result word leaves per cycle while rsp_ch.ready is high; an input word is
// taken every cycle while its results fit that pace. A word's results hold the
// result queue until the last one leaves: 5 for a tx packet start in LLC mode, 2 on rx lock.
// Each input word is registered before its results are loaded into the result queue.
// reset is synchronous, active high; the result queue only stalls on rsp_ch.ready.
`default_nettype none

module pppoa_encap_detect_strip_top
   import ped_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   ped_stream_if.sink      req_ch,
   ped_stream_if.source    rsp_ch,
   input  wire logic       csr_we,
   input  wire logic       csr_index,
   input  wire logic [1:0] csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;
   logic         burst_free;
   logic         fire;
   logic         accept;
   burst_type    burst;

   assign fire         = in_valid_ff && burst_free;
   assign req_ch.ready = !in_valid_ff || fire;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_word_in  = '{req_ch.func, req_ch.data_byte, req_ch.pkt_last};
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
   end

   ped_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .word      (in_word_ff),
      .burst     (burst)
   );

   ped_burst u_burst (
      .clock  (clock),
      .reset  (reset),
      .load   (fire),
      .burst  (burst),
      .free   (burst_free),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import ped_pkg::*;

   localparam logic        FUNC_TX       = 1'b1;
   localparam logic [47:0] LLC_LCP_SEQ   = 48'hfefe_03cf_c021;
   localparam int          STALL_LIMIT   = 4000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          PHASE_WORDS   = 30;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [1:0] csr_wdata;

   ped_stream_if req_if();
   ped_stream_if rsp_if();

   pppoa_encap_detect_strip_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted engine state
   logic [1:0] cfg_mode;
   logic       chan_up;
   logic [1:0] cur_mode;
   logic [2:0] hdr_pos;
   logic       rx_drop;
   logic       hdr_done;
   logic       drop_quiet;
   logic       tx_start;

   rsp_word_type due_results[$];

   int error_count  = 0;
   int words_sent   = 0;
   int results_seen = 0;
   int csr_writes   = 0;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int quiet_cycles = 0;

   function automatic logic [7:0] hdr_seq_byte(input int p);
      return LLC_LCP_SEQ[47 - 8*p -: 8];
   endfunction

   function automatic void expect_word(input logic [1:0] k, input logic [7:0] b,
                                       input logic l);
      rsp_word_type r;
      r.kind     = k;
      r.out_byte = b;
      r.out_last = l;
      due_results.push_back(r);
   endfunction

   function automatic void rx_restart();
      hdr_pos    = '0;
      rx_drop    = 1'b0;
      hdr_done   = 1'b0;
      drop_quiet = 1'b0;
   endfunction

   // LCP id seen: lock the mode and regenerate C0 21
   function automatic void rx_lock(input logic [1:0] m, input logic last);
      cur_mode = m;
      hdr_done = 1'b1;
      expect_word(KIND_RX, LCP_HI, 1'b0);
      expect_word(KIND_RX, LCP_LO, last);
   endfunction

   function automatic void strip_rx_byte(input logic [7:0] b, input logic last);
      logic [1:0] mode;
      logic       matched;
      logic       locked;
      mode    = cur_mode;
      matched = 1'b0;
      locked  = 1'b0;
      if (rx_drop) begin
         if (last) begin
            if (!drop_quiet) expect_word(KIND_ERR, 8'h00, 1'b1);
            rx_restart();
         end
         return;
      end
      // channel state only matters at the first byte
      if (!hdr_done && hdr_pos == 0 && !chan_up) begin
         if (last) begin
            rx_restart();
         end else begin
            rx_drop    = 1'b1;
            drop_quiet = 1'b1;
         end
         return;
      end
      if (hdr_done || mode == MODE_VCMUX) begin
         hdr_done = 1'b1;
         expect_word(KIND_RX, b, last);
         if (last) rx_restart();
         return;
      end
      if (mode == MODE_LLC) begin
         if (hdr_pos < 4 && b == hdr_seq_byte(hdr_pos)) begin
            matched = 1'b1;
            hdr_pos = hdr_pos + 3'd1;
            if (hdr_pos == 4) hdr_done = 1'b1;
         end
      end else begin
         // autodetect, mode three included
         if (hdr_pos == 0) begin
            if (b == LLC_B0) begin
               hdr_pos = 3'd1;
               matched = 1'b1;
            end else if (b == LCP_HI) begin
               hdr_pos = 3'd6;
               matched = 1'b1;
            end
         end else if (hdr_pos <= 5) begin
            if (b == hdr_seq_byte(hdr_pos)) begin
               matched = 1'b1;
               if (hdr_pos == 5) begin
                  rx_lock(MODE_LLC, last);
                  locked = 1'b1;
               end else begin
                  hdr_pos = hdr_pos + 3'd1;
               end
            end
         end else if (hdr_pos == 6) begin
            if (b == LCP_LO) begin
               matched = 1'b1;
               rx_lock(MODE_VCMUX, last);
               locked = 1'b1;
            end
         end
      end
      if (!matched) begin
         if (last) begin
            expect_word(KIND_ERR, 8'h00, 1'b1);
            rx_restart();
         end else begin
            rx_drop    = 1'b1;
            drop_quiet = 1'b0;
         end
         return;
      end
      if (last) begin
         if (!hdr_done) expect_word(KIND_ERR, 8'h00, 1'b1);
         else if (!locked) expect_word(KIND_EMPTY, 8'h00, 1'b1);
         rx_restart();
      end
   endfunction

   function automatic void encap_tx_byte(input logic [7:0] b, input logic last);
      int i;
      if (tx_start && cur_mode == MODE_LLC) begin
         for (i = 0; i < 4; i++) expect_word(KIND_TX, hdr_seq_byte(i), 1'b0);
      end
      expect_word(KIND_TX, b, last);
      tx_start = last;
   endfunction

   task automatic send_word(input req_word_type w);
      if ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_if.valid     <= 1'b1;
      req_if.func      <= w.func;
      req_if.data_byte <= w.data_byte;
      req_if.pkt_last  <= w.pkt_last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (w.func == FUNC_RX) strip_rx_byte(w.data_byte, w.pkt_last);
      else encap_tx_byte(w.data_byte, w.pkt_last);
      words_sent++;
   endtask

   // bytes go out most significant first, n of them
   task automatic send_pkt(input logic f, input int n, input logic [47:0] bytes);
      req_word_type w;
      int i;
      for (i = 0; i < n; i++) begin
         w.func      = f;
         w.data_byte = bytes[8*(n-1-i) +: 8];
         w.pkt_last  = (i == n - 1);
         send_word(w);
      end
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [1:0] val);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ENCAP_MODE) begin
         cfg_mode = val;
         cur_mode = val;
      end else begin
         chan_up = val[0];
      end
      csr_writes++;
   endtask

   task automatic write_rand_reg();
      if ($urandom_range(1)) write_reg(CSR_ENCAP_MODE, 2'($urandom_range(3)));
      else write_reg(CSR_CHANNEL_UP,
                     {1'($urandom_range(1)), 1'($urandom_range(99) < 75)});
   endtask

   task automatic test_channel_down();
      write_reg(CSR_CHANNEL_UP, 2'd0);
      send_pkt(FUNC_RX, 2, 48'hc021);
   endtask

   task automatic test_autodetect();
      write_reg(CSR_CHANNEL_UP, 2'd1);
      send_pkt(FUNC_RX, 3, 48'hc021ff);
      write_reg(CSR_ENCAP_MODE, MODE_AUTO);
      send_pkt(FUNC_RX, 6, LLC_LCP_SEQ);
   endtask

   task automatic test_llc_strip();
      write_reg(CSR_ENCAP_MODE, MODE_LLC);
      send_pkt(FUNC_RX, 4, 48'hfefe03cf);
      send_pkt(FUNC_RX, 3, 48'hfe7f00);
      send_pkt(FUNC_RX, 2, 48'hfefe);
      send_pkt(FUNC_RX, 1, 48'h5a);
   endtask

   task automatic test_tx_encap();
      send_pkt(FUNC_TX, 2, 48'h00ff);
      write_reg(CSR_ENCAP_MODE, 2'd3);
      send_pkt(FUNC_TX, 1, 48'hff);
      send_pkt(FUNC_RX, 2, 48'hc021);
   endtask

   task automatic test_mode_midpacket();
      write_reg(CSR_ENCAP_MODE, MODE_AUTO);
      send_pkt(FUNC_RX, 1, 48'h00) ;
      send_word('{func: FUNC_RX, data_byte: LCP_HI, pkt_last: 1'b0});
      // waiting for 21 in autodetect is no valid LLC position
      write_reg(CSR_ENCAP_MODE, MODE_LLC);
      send_word('{func: FUNC_RX, data_byte: LCP_LO, pkt_last: 1'b1});
      write_reg(CSR_ENCAP_MODE, MODE_VCMUX);
   endtask

   task automatic send_rand_pkt();
      logic [7:0]   pkt [0:11];
      req_word_type w;
      int           n, sel, cut, cnt, i;
      logic         f;
      f   = ($urandom_range(99) < 25) ? FUNC_TX : FUNC_RX;
      sel = $urandom_range(99);
      n   = 0;
      cnt = $urandom_range(0, 4);
      if (sel < 35) begin
         for (i = 0; i < 4; i++) begin
            pkt[n] = hdr_seq_byte(i);
            n++;
         end
         if ($urandom_range(1)) begin
            pkt[n] = LCP_HI;
            pkt[n+1] = LCP_LO;
            n += 2;
         end
      end else if (sel < 60) begin
         pkt[0] = LCP_HI;
         pkt[1] = LCP_LO;
         n = 2;
      end else if (sel < 75) begin
         // cut short, maybe with one bit flipped in the final header byte
         cut = $urandom_range(1, 5);
         for (i = 0; i < cut; i++) begin
            pkt[n] = hdr_seq_byte(i);
            n++;
         end
         if ($urandom_range(1)) pkt[n-1] = pkt[n-1] ^ (8'h01 << $urandom_range(7));
         cnt = 0;
      end else begin
         cnt = $urandom_range(1, 5);
      end
      for (i = 0; i < cnt; i++) begin
         pkt[n] = 8'($urandom_range(255));
         n++;
      end
      for (i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(99) < 4) write_rand_reg();
         w.func      = f;
         w.data_byte = pkt[i];
         w.pkt_last  = (i == n - 1);
         send_word(w);
      end
   endtask

   task automatic test_random(input int n);
      int stop_at;
      stop_at = words_sent + n;
      while (words_sent < stop_at) begin
         if ($urandom_range(99) < 8) write_rand_reg();
         send_rand_pkt();
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_result
      rsp_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         results_seen++;
         if (due_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word: expected none, got kind=%0d byte=%02h last=%0d",
                     $time, rsp_if.kind, rsp_if.out_byte, rsp_if.out_last);
         end else begin
            want = due_results.pop_front();
            if (rsp_if.kind !== want.kind) begin
               error_count++;
               $display("%0t: kind mismatch: expected %0d, got %0d",
                        $time, want.kind, rsp_if.kind);
            end
            if (rsp_if.out_byte !== want.out_byte) begin
               error_count++;
               $display("%0t: out_byte mismatch: expected %02h, got %02h",
                        $time, want.out_byte, rsp_if.out_byte);
            end
            if (rsp_if.out_last !== want.out_last) begin
               error_count++;
               $display("%0t: out_last mismatch: expected %0d, got %0d",
                        $time, want.out_last, rsp_if.out_last);
            end
         end
      end
   end

   // no word moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, due_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int ph;
      int directed_words;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = 1'b0;
      csr_wdata        = 2'd0;
      req_if.valid     = 1'b0;
      req_if.func      = 1'b0;
      req_if.data_byte = 8'h00;
      req_if.pkt_last  = 1'b0;
      req_if.kind      = 2'd0;
      req_if.out_byte  = 8'h00;
      req_if.out_last  = 1'b0;
      cfg_mode         = MODE_AUTO;
      cur_mode         = MODE_AUTO;
      chan_up          = 1'b0;
      tx_start         = 1'b1;
      rx_restart();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_channel_down();
      test_autodetect();
      test_llc_strip();
      test_tx_encap();
      test_mode_midpacket();
      directed_words = words_sent;

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 69;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 69;
            end
            default: begin
               idle_pct  = 7;
               stall_pct = 7;
            end
         endcase
         test_random(PHASE_WORDS);
      end
      settle();

      $display("Run: %0d words in (%0d directed), %0d results checked, %0d register writes",
               words_sent, directed_words, results_seen, csr_writes);
      $display("Pacing: free flow, sparse sender, stalling receiver, light gaps on both");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ped_pkg.sv
hw/rtl/ped_stream_if.sv
hw/rtl/ped_core.sv
hw/rtl/ped_burst.sv
hw/rtl/pppoa_encap_detect_strip_top.sv
sim/testbench.sv
